FILE: rtl/lswc_pkg.sv
// ----------------------------------------------------------------------------
// lswc_pkg
// shared types, widths and codes of the line segment window clipper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lswc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int QUO_W       = PROD_W + 1;
  localparam int SUM_W       = PROD_W + 2;
  localparam int DIV_CNT_W   = $clog2(PROD_W + 1);
  localparam int MAX_STEPS   = 8;
  localparam int STEP_W      = $clog2(MAX_STEPS + 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd3;

  localparam logic [3:0] CODE_LEFT   = 4'b0001;
  localparam logic [3:0] CODE_RIGHT  = 4'b0010;
  localparam logic [3:0] CODE_BOTTOM = 4'b0100;
  localparam logic [3:0] CODE_TOP    = 4'b1000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_seg_t;

  typedef struct packed {
    logic   accepted;
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
  } out_seg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_OPS,
    ST_MUL,
    ST_DIVS,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic ops;
    logic mul;
    logic div_start;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic all_in;
    logic trivial_reject;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/lswc_div.sv
// ----------------------------------------------------------------------------
// lswc_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lswc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [lswc_pkg::PROD_W-1:0]  dividend,
  input  wire logic [lswc_pkg::DIFF_W-1:0]  divisor,
  output logic                              busy,
  output logic [lswc_pkg::PROD_W-1:0]       quotient
);
  import lswc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIFF_W-1:0]    rem_r, rem_nxt;
  logic [PROD_W-1:0]    quo_r, quo_nxt;
  logic [DIFF_W-1:0]    den_r, den_nxt;
  logic [DIFF_W:0]      shifted;
  logic [DIFF_W:0]      trial;

  always_comb begin
    shifted  = {rem_r, quo_r[PROD_W-1]};
    trial    = shifted - {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(PROD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = trial[DIFF_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIFF_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/lswc_dp.sv
// ----------------------------------------------------------------------------
// lswc_dp
// clipper datapath: window registers, endpoints, outcodes, multiply, divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lswc_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [lswc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lswc_pkg::COORD_WIDTH-1:0] cfg_data,
  input  wire lswc_pkg::in_seg_t                in_data,
  input  wire lswc_pkg::cmd_t                   cmd,
  output lswc_pkg::status_t                     status,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output lswc_pkg::out_seg_t                    out_data
);
  import lswc_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (COORD_WIDTH - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  function automatic logic [3:0] outcode(coord_t x, coord_t y, coord_t l, coord_t r,
                                         coord_t b, coord_t t);
    logic [3:0] c;
    c = '0;
    if (x < l) c = c | CODE_LEFT;
    else if (x > r) c = c | CODE_RIGHT;
    if (y < b) c = c | CODE_BOTTOM;
    else if (y > t) c = c | CODE_TOP;
    return c;
  endfunction

  coord_t win_l_r, win_r_r, win_b_r, win_t_r;
  coord_t x1_r, y1_r, x2_r, y2_r;
  logic [3:0] c1, c2, co;

  // operand registers of one clip step
  logic signed [DIFF_W-1:0] d_r, num_r, den_r;
  coord_t                   base_r, edge_r;
  logic                     horiz_r;   // top or bottom edge: y moves to the edge
  logic                     first_r;   // start point moves
  logic signed [PROD_W-1:0] prod_r;
  logic                     neg_r, den_zero_r;

  logic [PROD_W-1:0]        prod_mag;
  logic [DIFF_W-1:0]        den_mag;
  logic                     div_busy;
  logic [PROD_W-1:0]        quo;
  logic signed [QUO_W-1:0]  q_s;
  logic signed [SUM_W-1:0]  sum;
  coord_t                   moved;

  logic     acc_r;
  logic     out_valid_r;
  out_seg_t out_r;

  assign c1 = outcode(x1_r, y1_r, win_l_r, win_r_r, win_b_r, win_t_r);
  assign c2 = outcode(x2_r, y2_r, win_l_r, win_r_r, win_b_r, win_t_r);
  assign co = (c1 != 4'b0) ? c1 : c2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_l_r <= coord_t'(-3680);
      win_r_r <= coord_t'(3680);
      win_b_r <= coord_t'(-4640);
      win_t_r <= coord_t'(4640);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:   win_l_r <= cfg_data;
        REG_RIGHT:  win_r_r <= cfg_data;
        REG_BOTTOM: win_b_r <= cfg_data;
        REG_TOP:    win_t_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // step operands from the selected edge
  always_ff @(posedge clk) begin
    if (cmd.ops) begin
      first_r <= (c1 != 4'b0);
      if ((co & (CODE_TOP | CODE_BOTTOM)) != 4'b0) begin
        horiz_r <= 1'b1;
        edge_r  <= ((co & CODE_TOP) != 4'b0) ? win_t_r : win_b_r;
        num_r   <= DIFF_W'(((co & CODE_TOP) != 4'b0) ? win_t_r : win_b_r) - DIFF_W'(y1_r);
        d_r     <= DIFF_W'(x2_r) - DIFF_W'(x1_r);
        den_r   <= DIFF_W'(y2_r) - DIFF_W'(y1_r);
        base_r  <= x1_r;
      end else begin
        horiz_r <= 1'b0;
        edge_r  <= ((co & CODE_RIGHT) != 4'b0) ? win_r_r : win_l_r;
        num_r   <= DIFF_W'(((co & CODE_RIGHT) != 4'b0) ? win_r_r : win_l_r) - DIFF_W'(x1_r);
        d_r     <= DIFF_W'(y2_r) - DIFF_W'(y1_r);
        den_r   <= DIFF_W'(x2_r) - DIFF_W'(x1_r);
        base_r  <= y1_r;
      end
    end
    if (cmd.mul) begin
      prod_r     <= d_r * num_r;
      den_zero_r <= (den_r == '0);
    end
  end

  always_comb begin
    prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    den_mag  = den_r[DIFF_W-1] ? DIFF_W'(-den_r) : DIFF_W'(den_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= prod_r[PROD_W-1] ^ den_r[DIFF_W-1];
    end
  end

  lswc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_mag),
    .divisor  (den_mag),
    .busy     (div_busy),
    .quotient (quo)
  );

  // signed quotient, zero divisor gives zero, then saturated add
  always_comb begin
    q_s = den_zero_r ? '0 : (neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));
    sum = SUM_W'(base_r) + SUM_W'(q_s);
    if (sum > SAT_HI) moved = coord_t'(SAT_HI);
    else if (sum < SAT_LO) moved = coord_t'(SAT_LO);
    else moved = coord_t'(sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r <= in_data.start_x;
      y1_r <= in_data.start_y;
      x2_r <= in_data.end_x;
      y2_r <= in_data.end_y;
    end else if (cmd.update) begin
      if (first_r) begin
        x1_r <= horiz_r ? moved : edge_r;
        y1_r <= horiz_r ? edge_r : moved;
      end else begin
        x2_r <= horiz_r ? moved : edge_r;
        y2_r <= horiz_r ? edge_r : moved;
      end
    end
    if (cmd.eval) begin
      acc_r <= ((c1 | c2) == 4'b0);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_r.accepted        <= acc_r;
      out_r.clipped_start_x <= acc_r ? x1_r : '0;
      out_r.clipped_start_y <= acc_r ? y1_r : '0;
      out_r.clipped_end_x   <= acc_r ? x2_r : '0;
      out_r.clipped_end_y   <= acc_r ? y2_r : '0;
    end
  end

  assign status.all_in         = ((c1 | c2) == 4'b0);
  assign status.trivial_reject = ((c1 & c2) != 4'b0);
  assign status.div_busy       = div_busy;
  assign status.out_free       = !out_valid_r || out_ready;
  assign out_valid             = out_valid_r;
  assign out_data              = out_r;

endmodule

`default_nettype wire

FILE: rtl/lswc_ctrl.sv
// ----------------------------------------------------------------------------
// lswc_ctrl
// clipper sequencer: outcode tests, clip steps, step cap and result handoff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lswc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lswc_pkg::status_t status,
  output lswc_pkg::cmd_t         cmd
);
  import lswc_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVAL;
          step_nxt  = '0;
        end
      end
      ST_EVAL: begin
        if (status.all_in || status.trivial_reject || step_r == STEP_W'(MAX_STEPS)) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_OPS;
        end
      end
      ST_OPS:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIVS;
      ST_DIVS: state_nxt = ST_DIV;
      ST_DIV: begin
        if (!status.div_busy) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ST_EVAL;
        step_nxt  = step_r + 1'b1;
      end
      ST_FIN: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EVAL: cmd.eval      = 1'b1;
      ST_OPS:  cmd.ops       = 1'b1;
      ST_MUL:  cmd.mul       = 1'b1;
      ST_DIVS: cmd.div_start = 1'b1;
      ST_UPD:  cmd.update    = 1'b1;
      ST_FIN:  cmd.finish    = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_W'(MAX_STEPS))
    else $error("clip step count above cap");

  a_div_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == ST_DIV && status.div_busy))
    else $error("divider not busy after start");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> status.out_free)
    else $error("result written over a pending transfer");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == ST_IDLE)
    else $error("sequencer not idle after result");

endmodule

`default_nettype wire

FILE: rtl/line_segment_window_clipper.sv
// ----------------------------------------------------------------------------
// line_segment_window_clipper
// cohen-sutherland clipping of one segment against a configured window
// ----------------------------------------------------------------------------
// sequence: a segment settled by its first outcode test goes to the result;
//   otherwise clip steps follow (operands, multiply, 34-bit serial divide,
//   update), at most 8 steps, before the result is written
// throughput: one segment at a time; the serial divider sets the step cost
// reset: synchronous active-low rst_n loads the default window
//   (-3680, 3680, -4640, 4640) and empties the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_segment_window_clipper (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [lswc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lswc_pkg::COORD_WIDTH-1:0] cfg_data,
  // segment in
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lswc_pkg::in_seg_t                in_data,
  // clipped result out
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output lswc_pkg::out_seg_t                    out_data
);
  import lswc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: decides accept, reject or next clip step
  lswc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: window, endpoints, intersection math and result register;
  // a new segment can transfer in while the previous result still waits
  lswc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/line_segment_window_clipper_tb.sv
// ----------------------------------------------------------------------------
// line_segment_window_clipper_tb
// checks the window clipper against its own outcode and clip-step predictor
// over directed segments and random ones, under several window settings,
// with random idle bursts on the segment side and random stalls on the
// result side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_segment_window_clipper_tb;
  import lswc_pkg::*;

  localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer before giving up
  localparam int SETTLE_WAIT  = 330;   // worst-case segment latency plus margin
  localparam int PHASE_ITEMS  = 225;

  // scoreboard: window copy, predicted clips, mismatch count
  class clip_scoreboard;
    coord_t   win_left, win_right, win_bottom, win_top;
    out_seg_t expected_clips[$];
    int       mismatches;
    int       segments_in;
    int       results_ok;
    int       accepted_seen;

    function new();
      win_left = -16'sd3680;
      win_right = 16'sd3680;
      win_bottom = -16'sd4640;
      win_top = 16'sd4640;
      mismatches = 0;
      segments_in = 0;
      results_ok = 0;
      accepted_seen = 0;
    endfunction

    function void set_window(logic [CFG_IDX_W-1:0] idx, coord_t v);
      case (idx)
        REG_LEFT:   win_left = v;
        REG_RIGHT:  win_right = v;
        REG_BOTTOM: win_bottom = v;
        REG_TOP:    win_top = v;
        default: ;
      endcase
    endfunction

    function logic [3:0] region_code(longint x, longint y);
      logic [3:0] c;
      c = 4'b0000;
      if (x < longint'(win_left)) c |= CODE_LEFT;
      else if (x > longint'(win_right)) c |= CODE_RIGHT;
      if (y < longint'(win_bottom)) c |= CODE_BOTTOM;
      else if (y > longint'(win_top)) c |= CODE_TOP;
      return c;
    endfunction

    // exact product, quotient truncated toward zero, zero divisor gives 0
    function longint scaled_ratio(longint a, longint b, longint c);
      if (c == 0) return 0;
      return (a * b) / c;
    endfunction

    function longint clamp_coord(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function out_seg_t clip_segment(in_seg_t s);
      out_seg_t   r;
      longint     x1, y1, x2, y2, nx, ny;
      logic [3:0] c1, c2, co;
      logic       vis;
      x1 = s.start_x; y1 = s.start_y; x2 = s.end_x; y2 = s.end_y;
      c1 = region_code(x1, y1);
      c2 = region_code(x2, y2);
      vis = 1'b0;
      for (int step = 0; step <= MAX_STEPS; step++) begin
        if ((c1 | c2) == 4'b0000) begin
          vis = 1'b1;
          break;
        end
        if ((c1 & c2) != 4'b0000 || step == MAX_STEPS) break;
        co = (c1 != 4'b0000) ? c1 : c2;
        if ((co & CODE_TOP) != 0) begin
          nx = clamp_coord(x1 + scaled_ratio(x2 - x1, longint'(win_top) - y1, y2 - y1));
          ny = win_top;
        end else if ((co & CODE_BOTTOM) != 0) begin
          nx = clamp_coord(x1 + scaled_ratio(x2 - x1, longint'(win_bottom) - y1, y2 - y1));
          ny = win_bottom;
        end else if ((co & CODE_RIGHT) != 0) begin
          ny = clamp_coord(y1 + scaled_ratio(y2 - y1, longint'(win_right) - x1, x2 - x1));
          nx = win_right;
        end else begin
          ny = clamp_coord(y1 + scaled_ratio(y2 - y1, longint'(win_left) - x1, x2 - x1));
          nx = win_left;
        end
        if (co == c1) begin
          x1 = nx; y1 = ny; c1 = region_code(x1, y1);
        end else begin
          x2 = nx; y2 = ny; c2 = region_code(x2, y2);
        end
      end
      r = '0;
      r.accepted = vis;
      if (vis) begin
        r.clipped_start_x = coord_t'(x1);
        r.clipped_start_y = coord_t'(y1);
        r.clipped_end_x = coord_t'(x2);
        r.clipped_end_y = coord_t'(y2);
      end
      return r;
    endfunction

    function void note_segment(in_seg_t s);
      expected_clips = {expected_clips, clip_segment(s)};
      segments_in++;
    endfunction

    task report(string what, longint got, longint want);
      mismatches++;
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task check_result(out_seg_t got);
      out_seg_t want;
      int       prior;
      if (expected_clips.size() == 0) begin
        report("result with nothing pending, accepted", got.accepted, 0);
        return;
      end
      want = expected_clips.pop_front();
      prior = mismatches;
      if (got.accepted !== want.accepted)
        report("accepted", got.accepted, want.accepted);
      if (got.clipped_start_x !== want.clipped_start_x)
        report("clipped_start_x", got.clipped_start_x, want.clipped_start_x);
      if (got.clipped_start_y !== want.clipped_start_y)
        report("clipped_start_y", got.clipped_start_y, want.clipped_start_y);
      if (got.clipped_end_x !== want.clipped_end_x)
        report("clipped_end_x", got.clipped_end_x, want.clipped_end_x);
      if (got.clipped_end_y !== want.clipped_end_y)
        report("clipped_end_y", got.clipped_end_y, want.clipped_end_y);
      if (mismatches == prior) results_ok++;
      if (want.accepted) accepted_seen++;
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [COORD_WIDTH-1:0] cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_seg_t                in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_seg_t               out_data;

  clip_scoreboard sb = new();
  bit             quiet = 1'b0;   // no idling in the last part of the run
  int             idle_cycles = 0;
  int             phase_count = 0;

  line_segment_window_clipper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: every sample taken at the edge, before any driver update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_segment(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("line_segment_window_clipper_tb: errors");
      $finish;
    end
  end

  // result side: random stall bursts mixed with open stretches
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // one segment transfer, with an optional idle burst ahead of it
  task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    in_seg_t s;
    s.start_x = sx; s.start_y = sy; s.end_x = ex; s.end_y = ey;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait until every predicted clip has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_clips.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_window(coord_t l, coord_t r, coord_t b, coord_t t);
    logic [CFG_IDX_W-1:0] idx [4];
    coord_t               val [4];
    idx = '{REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP};
    val = '{l, r, b, t};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      sb.set_window(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // coordinate near an edge of the window, clamped to the field range
  function automatic coord_t near_edge(coord_t e);
    int v;
    case ($urandom_range(0, 3))
      0: v = e;
      1: v = int'(e) + int'($urandom_range(0, 8)) - 4;
      default: v = int'(e) + int'($urandom_range(0, 2000)) - 1000;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  function automatic coord_t pick_x();
    case ($urandom_range(0, 4))
      0: return coord_t'($urandom);
      1: return near_edge(sb.win_left);
      2: return near_edge(sb.win_right);
      default: return coord_t'($urandom_range(0, 16000) - 8000);
    endcase
  endfunction

  function automatic coord_t pick_y();
    case ($urandom_range(0, 4))
      0: return coord_t'($urandom);
      1: return near_edge(sb.win_bottom);
      2: return near_edge(sb.win_top);
      default: return coord_t'($urandom_range(0, 20000) - 10000);
    endcase
  endfunction

  task automatic random_phase(int n);
    coord_t sx, sy;
    for (int i = 0; i < n; i++) begin
      sx = pick_x();
      sy = pick_y();
      // a share of horizontal and vertical segments
      case ($urandom_range(0, 9))
        0: send_segment(sx, sy, pick_x(), sy);
        1: send_segment(sx, sy, sx, pick_y());
        default: send_segment(sx, sy, pick_x(), pick_y());
      endcase
      // hold the sender until the block has emptied, once, halfway through the second phase
      if (i == n / 2 && phase_count == 1) begin
        in_valid <= 1'b0;
        while (sb.expected_clips.size() != 0) @(posedge clk);
      end
    end
    phase_count++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, default window
    send_segment(16'sd0, 16'sd0, 16'sd100, 16'sd100);             // wholly in the window
    send_segment(-16'sd5000, 16'sd0, -16'sd4000, 16'sd10);        // both left
    send_segment(16'sd5000, 16'sd6000, 16'sd9000, 16'sd5000);     // both top-right
    send_segment(-16'sd5000, -16'sd6000, 16'sd5000, 16'sd6000);   // crosses the whole window
    send_segment(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_segment(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_segment(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);        // vertical
    send_segment(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0);        // horizontal
    send_segment(-16'sd3680, 16'sd4640, 16'sd3680, -16'sd4640);   // on the corners
    send_segment(16'sd5000, 16'sd5000, 16'sd5000, 16'sd5000);     // single point outside
    send_segment(16'sd7, -16'sd9, 16'sd7, -16'sd9);               // single point in the window
    send_segment(-16'sd5000, 16'sd4000, -16'sd3000, 16'sd6000);   // misses past a corner
    send_segment(16'sd0, 16'sd0, 16'sd30000, 16'sd1);             // one end outside
    send_segment(16'sd30000, -16'sd1, 16'sd0, 16'sd0);            // start outside
    send_segment(-16'sd3681, 16'sd0, 16'sd3681, 16'sd0);          // just past both sides
    send_segment(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_segment(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    drain_results();

    // full-range window: nothing is ever outside
    write_window(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_segment(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    random_phase(PHASE_ITEMS);
    drain_results();

    // inverted window: every point has some outcode
    write_window(16'sd2000, -16'sd2000, 16'sd1500, -16'sd1500);
    send_segment(16'sd0, 16'sd0, 16'sd100, 16'sd100);
    random_phase(PHASE_ITEMS);
    drain_results();

    // degenerate window at the top-right extreme
    write_window(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_segment(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    random_phase(PHASE_ITEMS);
    drain_results();

    // narrow window at the bottom-left extreme
    write_window(-16'sd32768, -16'sd32700, -16'sd32768, -16'sd32000);
    random_phase(PHASE_ITEMS);
    drain_results();

    // random windows
    for (int w = 0; w < 2; w++) begin
      write_window(coord_t'($urandom_range(0, 12000) - 16000),
                   coord_t'($urandom_range(0, 12000) + 4000),
                   coord_t'($urandom_range(0, 12000) - 16000),
                   coord_t'($urandom_range(0, 12000) + 4000));
      if (w == 1) quiet = 1'b1;
      random_phase(PHASE_ITEMS);
      drain_results();
    end

    $display("segments sent %0d, results checked clean %0d, visible %0d, windows %0d",
             sb.segments_in, sb.results_ok, sb.accepted_seen, phase_count + 1);
    $display("covered default, full-range, inverted, degenerate, edge and random windows");
    if (sb.mismatches == 0 && sb.expected_clips.size() == 0) begin
      $display("line_segment_window_clipper_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.expected_clips.size());
      $display("line_segment_window_clipper_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lswc_pkg.sv
rtl/lswc_div.sv
rtl/lswc_dp.sv
rtl/lswc_ctrl.sv
rtl/line_segment_window_clipper.sv
tb/line_segment_window_clipper_tb.sv
